/* src/pbca_pkg.sv */
// Shared types, constants and functions for the point bin color accumulator.
package pbca_pkg;

  localparam int COUNT_W = 24;
  localparam int COLOR_W = 9;
  localparam int OUTC_W = 17;
  localparam int IDX_W = 16;
  localparam int PAL_SLOTS = 32;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic {
    FUNC_PLOT = 1'b0,
    FUNC_READ = 1'b1
  } func_t;

  typedef struct packed {
    logic func;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic [4:0] palette_index;
    logic [15:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [15:0] bin_index;
    logic [23:0] hit_count;
    logic [16:0] red_out;
    logic [16:0] green_out;
    logic [16:0] blue_out;
  } out_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
  } rgb_t;

  // Queue entry between front and back.
  typedef struct packed {
    logic is_plot;
    logic in_range;
    logic [31:0] bin;
    rgb_t pal;
  } cmd_t;

  function automatic rgb_t pal_lookup(input logic [4:0] p);
    rgb_t c;
    c = '0;
    case (p)
      5'd0: c = '{9'd256, 9'd128, 9'd0};
      5'd1: c = '{9'd0, 9'd0, 9'd256};
      5'd2: c = '{9'd256, 9'd0, 9'd256};
      5'd3: c = '{9'd0, 9'd256, 9'd0};
      5'd4: c = '{9'd256, 9'd0, 9'd0};
      5'd5: c = '{9'd256, 9'd256, 9'd0};
      5'd6: c = '{9'd0, 9'd256, 9'd256};
      5'd7: c = '{9'd256, 9'd0, 9'd0};
      5'd8: c = '{9'd0, 9'd256, 9'd0};
      5'd9: c = '{9'd0, 9'd128, 9'd256};
      5'd10: c = '{9'd256, 9'd128, 9'd0};
      5'd11: c = '{9'd256, 9'd0, 9'd0};
      5'd12: c = '{9'd256, 9'd179, 9'd0};
      5'd13: c = '{9'd256, 9'd77, 9'd0};
      5'd14: c = '{9'd256, 9'd128, 9'd0};
      5'd15: c = '{9'd0, 9'd0, 9'd256};
      5'd16: c = '{9'd51, 9'd0, 9'd256};
      5'd17: c = '{9'd0, 9'd0, 9'd256};
      5'd18: c = '{9'd0, 9'd51, 9'd256};
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

/* src/pbca_front.sv */
// Front: bins a plot item or passes a read index, over two registered stages.
module pbca_front #(
  parameter int SIDE = 256,
  parameter int PALETTE_SIZE = 19
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  pbca_pkg::in_item_t in_item,
  output logic in_ready,
  output logic cmd_valid,
  output pbca_pkg::cmd_t cmd,
  input  logic cmd_ready
);

  localparam int HALF = SIDE / 2;
  localparam int HW = $clog2(HALF) + 2;
  localparam int PROD_W = 16 + HW;
  localparam longint NBINS = longint'(SIDE) * longint'(SIDE);
  localparam int PMAX = ((PALETTE_SIZE > pbca_pkg::PAL_SLOTS) ?
                         pbca_pkg::PAL_SLOTS : PALETTE_SIZE) - 1;
  // 2^38 / 10240 rounded up; exact truncated quotient for |n| < 2^26.
  localparam longint RECIP = (longint'(1) <<< 38) / 10240 + 1;

  logic s1_valid;
  logic s1_plot;
  logic [15:0] s1_read;
  logic [4:0] s1_pal;
  logic signed [PROD_W-1:0] s1_xp;
  logic signed [PROD_W-1:0] s1_yp;
  logic advance;

  logic out_valid;
  pbca_pkg::cmd_t out_cmd;

  assign advance = !out_valid || cmd_ready;
  assign in_ready = advance;
  assign cmd_valid = out_valid;
  assign cmd = out_cmd;

  function automatic logic [31:0] to_bin(input logic signed [PROD_W-1:0] prod);
    logic [PROD_W-1:0] mag;
    logic [63:0] q;
    logic signed [33:0] c;
    mag = prod[PROD_W-1] ? PROD_W'(-prod) : prod;
    q = (64'(mag) * 64'(RECIP)) >> 38;
    c = prod[PROD_W-1] ? -34'(q) : 34'(q);
    if (c > signed'(34'(HALF))) c = 34'(HALF);
    c = c + 34'(HALF) - 34'sd1;
    if (c < 0) c = '0;
    return c[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
      out_valid <= s1_valid;
    end
    if (advance) begin
      s1_plot <= (in_item.func == pbca_pkg::FUNC_PLOT);
      s1_read <= in_item.read_index;
      s1_pal <= (32'(in_item.palette_index) > PMAX) ? 5'(PMAX) : in_item.palette_index;
      s1_xp <= PROD_W'(in_item.x_pos) * PROD_W'(signed'(HW'(HALF)));
      s1_yp <= PROD_W'(in_item.y_pos) * PROD_W'(signed'(HW'(HALF)));
    end
  end

  logic [63:0] bin_full;
  always_comb begin
    bin_full = 64'(to_bin(s1_xp)) * 64'(SIDE) + 64'(to_bin(s1_yp));
    if (bin_full >= 64'(NBINS)) bin_full = 64'(NBINS) - 64'd1;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_cmd.is_plot <= s1_plot;
      out_cmd.pal <= pbca_pkg::pal_lookup(s1_pal);
      if (s1_plot) begin
        out_cmd.bin <= bin_full[31:0];
        out_cmd.in_range <= 1'b1;
      end else begin
        out_cmd.bin <= 32'(s1_read);
        out_cmd.in_range <= (64'(s1_read) < 64'(NBINS));
      end
    end
  end

endmodule

/* src/pbca_fifo.sv */
// Short command queue between front and back.
module pbca_fifo #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  input  pbca_pkg::cmd_t wr_data,
  output logic wr_ready,
  output logic rd_valid,
  output pbca_pkg::cmd_t rd_data,
  input  logic rd_ready
);

  localparam int AW = $clog2(DEPTH);

  pbca_pkg::cmd_t mem [DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [AW:0] cnt;
  logic do_wr;
  logic do_rd;

  assign wr_ready = (cnt != (AW+1)'(DEPTH));
  assign rd_valid = (cnt != '0);
  assign rd_data = mem[rp];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (do_wr) wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (do_rd) rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
    if (do_wr) mem[wp] <= wr_data;
  end

endmodule

/* src/pbca_back.sv */
// Back: clears the bin store, runs read-modify-write and normalizing division.
module pbca_back #(
  parameter int SIDE = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic normalize,
  input  logic cmd_valid,
  input  pbca_pkg::cmd_t cmd,
  output logic cmd_ready,
  output logic res_valid,
  output pbca_pkg::out_item_t res,
  input  logic res_ready,
  output logic busy
);

  localparam int NB = SIDE * SIDE;
  localparam int AW = $clog2(NB);
  localparam int WW = pbca_pkg::COUNT_W + 3 * pbca_pkg::COLOR_W;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_CALC, ST_DIV, ST_OUT
  } state_t;

  state_t state;
  logic [WW-1:0] mem [NB];
  logic [WW-1:0] rdata;
  logic [AW-1:0] addr;
  logic [AW:0] clr_idx;
  pbca_pkg::cmd_t cur;
  logic [pbca_pkg::COUNT_W-1:0] count;
  pbca_pkg::rgb_t col;
  logic [34:0] divisor;
  logic [1:0] ch;
  logic [4:0] bitn;
  logic [16:0] quo;
  logic [34:0] rem;
  logic [16:0] dend;
  logic [16:0] outc [3];

  logic [pbca_pkg::COUNT_W-1:0] old_cnt;
  pbca_pkg::rgb_t old_col;
  logic [35:0] trial;
  logic fits;
  logic [pbca_pkg::COUNT_W-1:0] calc_cnt;
  pbca_pkg::rgb_t calc_col;

  assign old_cnt = rdata[WW-1 -: pbca_pkg::COUNT_W];
  assign old_col = rdata[3*pbca_pkg::COLOR_W-1:0];
  assign cmd_ready = (state == ST_IDLE);
  assign res_valid = (state == ST_OUT);
  assign busy = (state != ST_IDLE);
  assign trial = {rem, dend[bitn]};
  assign fits = (trial >= 36'(divisor));

  always_comb begin
    case (ch)
      2'd0: dend = {col.r, 8'd0};
      2'd1: dend = {col.g, 8'd0};
      default: dend = {col.b, 8'd0};
    endcase
  end

  always_comb begin
    if (!cur.in_range) begin
      calc_cnt = '0;
      calc_col = '0;
    end else if (cur.is_plot) begin
      calc_cnt = (old_cnt == pbca_pkg::COUNT_MAX) ? old_cnt : old_cnt + 1'b1;
      calc_col.r = 9'((10'(old_col.r) + 10'(cur.pal.r)) >> 1);
      calc_col.g = 9'((10'(old_col.g) + 10'(cur.pal.g)) >> 1);
      calc_col.b = 9'((10'(old_col.b) + 10'(cur.pal.b)) >> 1);
    end else begin
      calc_cnt = old_cnt;
      calc_col = old_col;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) rdata <= mem[addr];
    if (state == ST_CLEAR) mem[clr_idx[AW-1:0]] <= '0;
    else if (state == ST_CALC && cur.is_plot) mem[addr] <= {calc_cnt, calc_col};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_idx <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == (AW+1)'(NB-1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            addr <= cmd.bin[AW-1:0];
            state <= ST_READ;
          end
        end
        ST_READ: state <= ST_CALC;
        ST_CALC: begin
          count <= calc_cnt;
          col <= calc_col;
          divisor <= (!normalize || calc_cnt == '0) ? 35'd1 : 35'(calc_cnt) * 35'd10;
          ch <= '0;
          bitn <= 5'd16;
          rem <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          quo[bitn] <= fits;
          if (bitn == 5'd0) begin
            outc[ch] <= {quo[16:1], fits};
            rem <= '0;
            bitn <= 5'd16;
            if (ch == 2'd2) state <= ST_OUT;
            else ch <= ch + 1'b1;
          end else begin
            rem <= fits ? 35'(trial - 36'(divisor)) : 35'(trial);
            bitn <= bitn - 1'b1;
          end
        end
        ST_OUT: if (res_ready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    res.bin_index = cur.bin[15:0];
    res.hit_count = count;
    res.red_out = outc[0];
    res.green_out = outc[1];
    res.blue_out = outc[2];
  end

endmodule

/* src/point_bin_color_accumulator.sv */
// Top level of the point bin color accumulator.
// An accepted input passes the registered front stages and the command queue,
// then the back part reads the bin, updates it and divides each color channel.
// The back part takes a new item only when idle, after the serial divider of the
// three color channels has finished and the previous result has been popped.
// Reset: rst clears control and normalize, then the bin store is cleared
// one bin at a time, during which at most six items are buffered.
module point_bin_color_accumulator #(
  parameter int SIDE = 256,
  parameter int PALETTE_SIZE = 19
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  pbca_pkg::in_item_t in_item,
  output logic full,
  output logic empty,
  output pbca_pkg::out_item_t out_item,
  input  logic pop,
  input  logic cfg_valid,
  input  logic cfg_data,
  output logic cfg_ready
);

  logic normalize;
  logic f_valid, f_ready, in_ready;
  pbca_pkg::cmd_t f_cmd;
  logic q_valid, q_ready, busy;
  pbca_pkg::cmd_t q_cmd;
  logic r_valid;
  pbca_pkg::out_item_t r_item;

  assign full = !in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) normalize <= 1'b0;
    else if (cfg_valid && cfg_ready) normalize <= cfg_data;
  end

  pbca_front #(.SIDE(SIDE), .PALETTE_SIZE(PALETTE_SIZE)) u_front (
    .clk(clk), .rst(rst), .in_valid(push), .in_item(in_item), .in_ready(in_ready),
    .cmd_valid(f_valid), .cmd(f_cmd), .cmd_ready(f_ready)
  );

  pbca_fifo #(.DEPTH(4)) u_fifo (
    .clk(clk), .rst(rst), .wr_valid(f_valid), .wr_data(f_cmd), .wr_ready(f_ready),
    .rd_valid(q_valid), .rd_data(q_cmd), .rd_ready(q_ready)
  );

  pbca_back #(.SIDE(SIDE)) u_back (
    .clk(clk), .rst(rst), .normalize(normalize), .cmd_valid(q_valid), .cmd(q_cmd),
    .cmd_ready(q_ready), .res_valid(r_valid), .res(r_item), .res_ready(pop),
    .busy(busy)
  );

  assign empty = !r_valid || !busy;
  assign out_item = r_item;

endmodule
